// ===== design/fcfd_pkg.sv =====
// Shared types and constants for the force command filter and drive block.
// Used by fcfd_parser, fcfd_filter and force_command_filter_drive.
package fcfd_pkg;

  // Line store limit and the width of the line length counter
  localparam int LINE_STORE_MAX = 19;
  localparam int LINE_LEN_W     = $clog2(LINE_STORE_MAX + 1);

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 16;
  localparam int ALPHA_W = 16;
  localparam int LIMIT_W = 10;
  localparam int EMA_W   = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD    = 2'd3;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 16'd9830;
  localparam logic               REVERSE_RST = 1'b1;
  localparam logic [LIMIT_W-1:0] SOFT_RST    = 10'd600;
  localparam logic [LIMIT_W-1:0] HARD_RST    = 10'd700;

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

  // Number parser phase, one-hot
  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // One received byte handed to the parser
  typedef struct packed {
    logic              strobe;
    logic [BYTE_W-1:0] data;
    logic              err;
  } rx_item_t;

  // Configuration register set
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               reverse;
    logic [LIMIT_W-1:0] soft_lim;
    logic [LIMIT_W-1:0] hard_lim;
  } cfg_t;

endpackage

// ===== design/force_command_filter_drive.sv =====
// Top level of the force command filter and H-bridge drive.
// Depends on fcfd_pkg, fcfd_parser and fcfd_filter.
//
// Input channel (in_valid / in_stall): one item per accepted cycle. A byte
// item (in_req_type = 0) feeds the command line parser and gives no result.
// A tick item (in_req_type = 1) updates the EMA filter and gives one result
// on the output channel: bridge direction bits, PWM duty and the current
// force command.
// A tick's result passes the input register, the middle register and the
// output register before it shows on out_valid.
// Throughput: one item per cycle while in_stall is low; the filter's
// multiply-add feeds its EMA register combinationally, so back-to-back
// ticks are taken. When out_stall is high the result holds in the output
// register; the middle and input registers still fill, and in_stall rises
// only once a tick cannot move forward. Byte items never wait on the output
// side. Configuration (cfg_we / cfg_index / cfg_data) is to be written by
// the user only while idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous) empties the pipeline, clears the line
// parser, the command and the filter, and loads the register defaults.
module force_command_filter_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [fcfd_pkg::BYTE_W-1:0]         in_rx_byte,
  input  logic                                in_rx_error,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_dir_a,
  output logic                                out_dir_b,
  output logic [fcfd_pkg::LIMIT_W-1:0]        out_duty,
  output logic signed [fcfd_pkg::CMD_W-1:0]   out_force_cmd,
  // configuration
  input  logic                                cfg_we,
  input  logic [fcfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcfd_pkg::CFG_W-1:0]          cfg_data
);
  import fcfd_pkg::*;

  localparam int Q_W = EMA_W - ALPHA_W;   // integer part magnitude width

  cfg_t cfg_r;

  // Input register
  logic              in_vld_r;
  logic              in_type_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_err_r;

  // Middle register (filtered value per tick)
  logic                    mid_vld_r, mid_vld_nxt;
  logic signed [EMA_W-1:0] mid_ema_r;
  logic signed [CMD_W-1:0] mid_cmd_r;

  // Output register
  logic               out_vld_r;
  logic               dir_a_r, dir_b_r;
  logic [LIMIT_W-1:0] duty_r;
  logic signed [CMD_W-1:0] fcmd_r;

  logic     out_load, mid_free, a_go, tick_go, accept;
  rx_item_t rx;
  logic signed [CMD_W-1:0] command;
  logic signed [EMA_W-1:0] ema_next;

  // Drive stage signals
  logic             f_neg;
  logic [EMA_W-1:0] ema_mag;
  logic [Q_W-1:0]   q_mag;
  logic [Q_W-1:0]   m_soft, m_hard;
  logic             nz;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha    <= ALPHA_RST;
      cfg_r.reverse  <= REVERSE_RST;
      cfg_r.soft_lim <= SOFT_RST;
      cfg_r.hard_lim <= HARD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:   cfg_r.alpha    <= cfg_data[ALPHA_W-1:0];
        CFG_REVERSE: cfg_r.reverse  <= cfg_data[0];
        CFG_SOFT:    cfg_r.soft_lim <= cfg_data[LIMIT_W-1:0];
        CFG_HARD:    cfg_r.hard_lim <= cfg_data[LIMIT_W-1:0];
        default:     cfg_r          <= cfg_r;
      endcase
    end
  end

  // Pipeline flow control
  assign out_load = !out_vld_r || !out_stall;
  assign mid_free = !mid_vld_r || out_load;
  assign a_go     = in_vld_r && ((in_type_r == REQ_BYTE) || mid_free);
  assign tick_go  = a_go && (in_type_r == REQ_TICK);
  assign in_stall = in_vld_r && !a_go;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (a_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_type_r <= in_req_type;
      in_byte_r <= in_rx_byte;
      in_err_r  <= in_rx_error;
    end
  end

  // Byte items go to the line parser
  assign rx.strobe = a_go && (in_type_r == REQ_BYTE);
  assign rx.data   = in_byte_r;
  assign rx.err    = in_err_r;

  fcfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx      (rx),
    .command (command)
  );

  fcfd_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .update   (tick_go),
    .alpha    (cfg_r.alpha),
    .command  (command),
    .ema_next (ema_next)
  );

  // Middle register
  always_comb begin
    if (tick_go) begin
      mid_vld_nxt = 1'b1;
    end else if (out_load) begin
      mid_vld_nxt = 1'b0;
    end else begin
      mid_vld_nxt = mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else begin
      mid_vld_r <= mid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      mid_ema_r <= ema_next;
      mid_cmd_r <= command;
    end
  end

  // Drive stage: sign, truncate toward zero on magnitude, two clamps
  assign f_neg   = mid_ema_r[EMA_W-1] ^ cfg_r.reverse;
  assign ema_mag = mid_ema_r[EMA_W-1] ? (EMA_W'(0) - mid_ema_r) : mid_ema_r;
  assign q_mag   = ema_mag[EMA_W-1 -: Q_W];
  assign m_soft  = (q_mag > Q_W'(cfg_r.soft_lim)) ? Q_W'(cfg_r.soft_lim) : q_mag;
  assign m_hard  = (m_soft > Q_W'(cfg_r.hard_lim)) ? Q_W'(cfg_r.hard_lim) : m_soft;
  assign nz      = (m_hard != '0);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && mid_vld_r) begin
      dir_a_r <= nz && f_neg;
      dir_b_r <= nz && !f_neg;
      duty_r  <= m_hard[LIMIT_W-1:0];
      fcmd_r  <= mid_cmd_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_dir_a     = dir_a_r;
  assign out_dir_b     = dir_b_r;
  assign out_duty      = duty_r;
  assign out_force_cmd = fcmd_r;

endmodule

// ===== design/fcfd_parser.sv =====
// Line assembler and decimal command parser for serial bytes.
// Depends on fcfd_pkg; holds the force command register.
module fcfd_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fcfd_pkg::rx_item_t              rx,
  output logic signed [fcfd_pkg::CMD_W-1:0] command
);
  import fcfd_pkg::*;

  logic [LINE_LEN_W-1:0] line_len_r, line_len_nxt;
  logic                  is_force_r, is_force_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [CMD_W-1:0]      accum_r, accum_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;

  // Line state as seen by this byte (an errored byte drops the line first)
  logic [LINE_LEN_W-1:0] len_e;
  logic                  is_force_e;
  phase_t                phase_e;
  logic                  neg_e;
  logic [CMD_W-1:0]      accum_e;

  logic             is_digit, is_space;
  logic [CMD_W-1:0] digit_val;
  logic [CMD_W-1:0] accum_x10;

  assign is_digit  = (rx.data >= CHAR_0) && (rx.data <= CHAR_9);
  assign is_space  = (rx.data == CHAR_SP) || ((rx.data >= CHAR_TAB) && (rx.data <= CHAR_CR));
  assign digit_val = CMD_W'(rx.data - CHAR_0);

  always_comb begin
    if (rx.err) begin
      len_e      = '0;
      is_force_e = 1'b0;
      phase_e    = PH_SKIP;
      neg_e      = 1'b0;
      accum_e    = '0;
    end else begin
      len_e      = line_len_r;
      is_force_e = is_force_r;
      phase_e    = phase_r;
      neg_e      = neg_r;
      accum_e    = accum_r;
    end
  end

  // accum * 10 as shifts, wraps to 16 bits
  assign accum_x10 = (accum_e << 3) + (accum_e << 1);

  // Next line and command state
  always_comb begin
    line_len_nxt = line_len_r;
    is_force_nxt = is_force_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    accum_nxt    = accum_r;
    cmd_nxt      = cmd_r;
    if (rx.strobe) begin
      line_len_nxt = len_e;
      is_force_nxt = is_force_e;
      phase_nxt    = phase_e;
      neg_nxt      = neg_e;
      accum_nxt    = accum_e;
      if (rx.data == CHAR_NL) begin
        // end of line: commit a force line, then start fresh
        if ((len_e != '0) && is_force_e) begin
          cmd_nxt = neg_e ? (CMD_W'(0) - accum_e) : accum_e;
        end
        line_len_nxt = '0;
        is_force_nxt = 1'b0;
        phase_nxt    = PH_SKIP;
        neg_nxt      = 1'b0;
        accum_nxt    = '0;
      end else if (len_e < LINE_LEN_W'(LINE_STORE_MAX)) begin
        line_len_nxt = len_e + 1'b1;
        if (len_e == '0) begin
          is_force_nxt = (rx.data == CHAR_F);
        end else begin
          case (phase_e)
            PH_SKIP: begin
              if (is_space) begin
                phase_nxt = PH_SKIP;
              end else if ((rx.data == CHAR_MINUS) || (rx.data == CHAR_PLUS)) begin
                neg_nxt   = (rx.data == CHAR_MINUS);
                phase_nxt = PH_NUM;
              end else if (is_digit) begin
                accum_nxt = digit_val;
                phase_nxt = PH_NUM;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_NUM: begin
              if (is_digit) begin
                accum_nxt = accum_x10 + digit_val;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              phase_nxt = phase_e;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
      is_force_r <= 1'b0;
      phase_r    <= PH_SKIP;
      neg_r      <= 1'b0;
      accum_r    <= '0;
      cmd_r      <= '0;
    end else begin
      line_len_r <= line_len_nxt;
      is_force_r <= is_force_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      accum_r    <= accum_nxt;
      cmd_r      <= cmd_nxt;
    end
  end

  assign command = $signed(cmd_r);

endmodule

// ===== design/fcfd_filter.sv =====
// Exponential moving average of the force command in Q15.16.
// Depends on fcfd_pkg; one update per tick.
module fcfd_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              update,
  input  logic        [fcfd_pkg::ALPHA_W-1:0] alpha,
  input  logic signed [fcfd_pkg::CMD_W-1:0]   command,
  output logic signed [fcfd_pkg::EMA_W-1:0]   ema_next
);
  import fcfd_pkg::*;

  localparam int PA_W  = ALPHA_W + 1 + CMD_W;   // alpha * cmd
  localparam int PB_W  = ALPHA_W + 2 + EMA_W;   // (1 - alpha) * ema
  localparam int ACC_W = PB_W + 1;

  logic signed [EMA_W-1:0]   ema_r;
  logic        [ALPHA_W:0]   beta;
  logic signed [PA_W-1:0]    prod_a;
  logic signed [PB_W-1:0]    prod_b;
  logic signed [ACC_W-1:0]   acc;

  // beta = 65536 - alpha, 17 bits
  assign beta   = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha};
  assign prod_a = $signed({1'b0, alpha}) * command;
  assign prod_b = $signed({1'b0, beta}) * ema_r;

  // acc = alpha * (cmd << 16) + beta * ema; floor divide by 2^16 is a shift
  assign acc = ACC_W'({prod_a, {ALPHA_W{1'b0}}}) + ACC_W'(prod_b);
  assign ema_next = acc[ALPHA_W +: EMA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_r <= '0;
    end else if (update) begin
      ema_r <= ema_next;
    end
  end

endmodule
